// ===== hdl/pwc_pkg.sv =====
// Package for the pulse width capture block.
// Holds the beat structs, configuration set, code enums and fixed constants.
// No dependencies; every other file of the block imports it.
package pwc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_MEAS = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        END_NONE    = 2'd0,
        END_NOSTART = 2'd1,
        END_IDLE    = 2'd2,
        END_FULL    = 2'd3
    } t_end;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UNIT          = 3'd0,
        CFG_IDLE_LIMIT    = 3'd1,
        CFG_START_TIMEOUT = 3'd2,
        CFG_MAX_PULSES    = 3'd3,
        CFG_MISS_LIMIT    = 3'd4
    } t_cfg_idx;

    localparam logic [15:0] UNIT_RST          = 16'd500;
    localparam logic [19:0] IDLE_LIMIT_RST    = 20'd5000;
    localparam logic [23:0] START_TIMEOUT_RST = 24'd100000;
    localparam logic [8:0]  MAX_PULSES_RST    = 9'd256;
    localparam logic [3:0]  MISS_LIMIT_RST    = 4'd3;

    localparam logic [3:0]  MISS_SAT  = 4'd15;
    localparam logic [15:0] UNITS_SAT = 16'hFFFF;

    typedef struct packed {
        logic arm;
        logic line_level;
    } t_in;

    typedef struct packed {
        logic        pulse_valid;
        logic        pulse_level;
        logic [15:0] pulse_units;
        logic [7:0]  pulse_index;
        logic        capture_done;
        logic [1:0]  end_reason;
        logic [8:0]  pulse_count;
        logic        link_up;
    } t_out;

    typedef struct packed {
        logic [15:0] unit_ticks;
        logic [19:0] idle_limit_ticks;
        logic [23:0] start_timeout_ticks;
        logic [8:0]  max_pulses;
        logic [3:0]  miss_limit;
    } t_cfg;

    typedef struct packed {
        logic head_valid;
        logic skid_valid;
        logic pop;
    } t_buf_stat;

endpackage

// ===== hdl/pulse_width_capture.sv =====
// Top level of the pulse width capture block with link monitor.
// Instantiates pwc_cfg_regs, pwc_core and pwc_out_buf; depends on pwc_pkg.
//
//   channel  direction  handshake                 payload
//   in       sink       i_in_valid / o_in_stall   i_in_data  (t_in, one sample per beat)
//   out      source     o_out_valid / i_out_stall o_out_data (t_out, zero or one per sample)
//   cfg      sink       i_cfg_we                  i_cfg_idx, i_cfg_data
//
// One sample beat is taken per cycle while o_in_stall is low; its result passes the input
// register of the core and then the output result register.
// Synchronous active-low reset returns the link to down and the capture to idle.
// The output register plus its skid stage absorb a stall; the input stalls when the beats
// left there plus the sample in the core could fill both, and in a register write cycle.
// A unit write stalls the input while the core adopts it, and during a timed segment until the rebuild ends.
module pulse_width_capture import pwc_pkg::*; #(
    parameter int MAX_PULSES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out                  o_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      cfg;
    t_out      res;
    t_buf_stat stat;
    logic      busy;
    logic      hold;
    logic      push;
    logic      accept;
    logic [1:0] occ;
    logic [1:0] need;

    pwc_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pwc_core #(
        .MAX_PULSES (MAX_PULSES)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_data (i_in_data),
        .i_cfg     (cfg),
        .o_busy    (busy),
        .o_hold    (hold),
        .o_push    (push),
        .o_res     (res)
    );

    pwc_out_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (res),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .o_stat  (stat)
    );

    // Room is reserved for the sample already in the core and the one being taken.
    assign occ        = {1'b0, stat.head_valid} + {1'b0, stat.skid_valid}
                      - {1'b0, stat.pop};
    assign need       = occ + {1'b0, busy};
    assign o_in_stall = (need >= 2'd2) || hold || i_cfg_we;
    assign accept     = i_in_valid && !o_in_stall;

endmodule

// ===== hdl/pwc_cfg_regs.sv =====
// Configuration register set of the pulse width capture block.
// Plain write port, no read-back; depends on pwc_pkg.
module pwc_cfg_regs import pwc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.unit_ticks          <= UNIT_RST;
            r_cfg.idle_limit_ticks    <= IDLE_LIMIT_RST;
            r_cfg.start_timeout_ticks <= START_TIMEOUT_RST;
            r_cfg.max_pulses          <= MAX_PULSES_RST;
            r_cfg.miss_limit          <= MISS_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_UNIT:          r_cfg.unit_ticks          <= i_cfg_data[15:0];
                CFG_IDLE_LIMIT:    r_cfg.idle_limit_ticks    <= i_cfg_data[19:0];
                CFG_START_TIMEOUT: r_cfg.start_timeout_ticks <= i_cfg_data[23:0];
                CFG_MAX_PULSES:    r_cfg.max_pulses          <= i_cfg_data[8:0];
                CFG_MISS_LIMIT:    r_cfg.miss_limit          <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/pwc_core.sv =====
// Capture core: input register, capture state and the single-pass step logic.
// Rounds segment lengths with a running quotient and sub-unit remainder; a serial
// divider rebuilds both when the unit changes during a segment. Depends on pwc_pkg.
module pwc_core import pwc_pkg::*; #(
    parameter int MAX_PULSES = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_in  i_in_data,
    input  t_cfg i_cfg,
    output logic o_busy,
    output logic o_hold,
    output logic o_push,
    output t_out o_res
);

    localparam int CW = $clog2(MAX_PULSES + 1);
    localparam int LW = (CW > 9) ? CW : 9;

    logic          r_in_valid;
    t_in           r_in;
    t_phase        r_phase, n_phase;
    logic [23:0]   r_wait, n_wait;
    logic [19:0]   r_seg, n_seg;
    logic          r_exp, n_exp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [3:0]    r_miss, n_miss;
    logic          r_link, n_link;
    logic [15:0]   r_q, n_q;
    logic [15:0]   r_r, n_r;
    logic [15:0]   r_ucur, n_ucur;
    logic [4:0]    r_dcnt, n_dcnt;
    logic [20:0]   r_dq, n_dq;
    logic [15:0]   r_rem, n_rem;

    logic [15:0]   u_eff;
    logic [16:0]   half_p1;
    logic          init_q;
    logic [15:0]   init_r;
    logic [LW-1:0] max_ext;
    logic [LW-1:0] lim;
    logic          div_done;
    logic [15:0]   div_q;
    logic [15:0]   div_r;

    always_comb begin
        u_eff   = (i_cfg.unit_ticks == 16'd0) ? 16'd1 : i_cfg.unit_ticks;
        half_p1 = {2'b00, u_eff[15:1]} + 17'd1;
        init_q  = (half_p1 >= {1'b0, u_eff});
        init_r  = init_q ? 16'(half_p1 - {1'b0, u_eff}) : half_p1[15:0];
        max_ext = LW'(i_cfg.max_pulses);
        if (max_ext == '0) begin
            lim = LW'(1);
        end else if (max_ext > LW'(MAX_PULSES)) begin
            lim = LW'(MAX_PULSES);
        end else begin
            lim = max_ext;
        end
    end

    // The quotient and remainder belong to the unit in r_ucur once a rebuild ends. When the unit
    // changes while a segment is timed, they are rebuilt one bit per cycle.
    always_comb begin
        logic [16:0] shifted;
        logic [16:0] diff;
        n_ucur   = r_ucur;
        n_dcnt   = r_dcnt;
        n_dq     = r_dq;
        n_rem    = r_rem;
        div_done = 1'b0;
        div_q    = '0;
        div_r    = '0;
        shifted  = {r_rem, r_dq[20]};
        diff     = shifted - {1'b0, u_eff};
        if (u_eff != r_ucur) begin
            n_ucur = u_eff;
            n_dcnt = '0;
            if (r_phase == PH_MEAS) begin
                n_dcnt = 5'd21;
                n_dq   = {1'b0, r_seg} + {6'd0, u_eff[15:1]};
                n_rem  = '0;
            end
        end else if (r_dcnt != 5'd0) begin
            n_dcnt = r_dcnt - 5'd1;
            if (shifted >= {1'b0, u_eff}) begin
                n_rem = diff[15:0];
                n_dq  = {r_dq[19:0], 1'b1};
            end else begin
                n_rem = shifted[15:0];
                n_dq  = {r_dq[19:0], 1'b0};
            end
            if (r_dcnt == 5'd1) begin
                div_done = 1'b1;
                div_q    = (n_dq[20:16] != 5'd0) ? UNITS_SAT : n_dq[15:0];
                div_r    = n_rem;
            end
        end
    end

    always_comb begin
        logic        do_finish;
        logic [24:0] wait_next;
        logic [20:0] seg_next;
        logic [16:0] r_inc;
        n_phase   = r_phase;
        n_wait    = r_wait;
        n_seg     = r_seg;
        n_exp     = r_exp;
        n_cnt     = r_cnt;
        n_miss    = r_miss;
        n_link    = r_link;
        n_q       = r_q;
        n_r       = r_r;
        o_push    = 1'b0;
        o_res     = '0;
        do_finish = 1'b0;
        wait_next = '0;
        seg_next  = '0;
        r_inc     = '0;
        if (r_in_valid) begin
            if (r_in.arm) begin
                n_phase = PH_WAIT;
                n_wait  = '0;
                n_seg   = '0;
                n_exp   = 1'b0;
                n_cnt   = '0;
            end
            case (n_phase)
                PH_WAIT: begin
                    if (!r_in.line_level) begin
                        n_phase = PH_MEAS;
                        n_exp   = 1'b0;
                        n_seg   = 20'd1;
                        n_q     = init_q ? 16'd1 : 16'd0;
                        n_r     = init_r;
                    end else begin
                        wait_next = {1'b0, n_wait} + 25'd1;
                        if (wait_next > {1'b0, i_cfg.start_timeout_ticks}) begin
                            o_push             = 1'b1;
                            o_res.capture_done = 1'b1;
                            o_res.end_reason   = END_NOSTART;
                            do_finish          = 1'b1;
                        end else begin
                            n_wait = wait_next[23:0];
                        end
                    end
                end
                PH_MEAS: begin
                    if (r_in.line_level == n_exp) begin
                        seg_next = {1'b0, n_seg} + 21'd1;
                        if (seg_next > {1'b0, i_cfg.idle_limit_ticks}) begin
                            o_push             = 1'b1;
                            o_res.capture_done = 1'b1;
                            o_res.end_reason   = END_IDLE;
                            do_finish          = 1'b1;
                        end else begin
                            n_seg = seg_next[19:0];
                            r_inc = {1'b0, n_r} + 17'd1;
                            if (r_inc == {1'b0, u_eff}) begin
                                n_r = '0;
                                if (n_q != UNITS_SAT) begin
                                    n_q = n_q + 16'd1;
                                end
                            end else begin
                                n_r = r_inc[15:0];
                            end
                        end
                    end else begin
                        o_push            = 1'b1;
                        o_res.pulse_valid = 1'b1;
                        o_res.pulse_level = n_exp;
                        o_res.pulse_units = (n_q == 16'd0) ? 16'd1 : n_q;
                        o_res.pulse_index = 8'(LW'(n_cnt));
                        n_cnt = n_cnt + CW'(1);
                        n_exp = ~n_exp;
                        n_seg = 20'd1;
                        n_q   = init_q ? 16'd1 : 16'd0;
                        n_r   = init_r;
                        if (LW'(n_cnt) >= lim) begin
                            o_res.capture_done = 1'b1;
                            o_res.end_reason   = END_FULL;
                            do_finish          = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            if (do_finish) begin
                if (n_cnt != '0) begin
                    n_miss = '0;
                    n_link = 1'b1;
                end else begin
                    if (n_miss < MISS_SAT) begin
                        n_miss = n_miss + 4'd1;
                    end
                    if (n_miss >= i_cfg.miss_limit) begin
                        n_link = 1'b0;
                    end
                end
                n_phase = PH_IDLE;
            end
            o_res.pulse_count = 9'(LW'(n_cnt));
            o_res.link_up     = n_link;
        end
        if (div_done) begin
            n_q = div_q;
            n_r = div_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_IDLE;
            r_wait     <= '0;
            r_seg      <= '0;
            r_exp      <= 1'b0;
            r_cnt      <= '0;
            r_miss     <= '0;
            r_link     <= 1'b0;
            r_q        <= '0;
            r_r        <= '0;
            r_ucur     <= UNIT_RST;
            r_dcnt     <= '0;
            r_dq       <= '0;
            r_rem      <= '0;
        end else begin
            r_in_valid <= i_accept;
            r_phase    <= n_phase;
            r_wait     <= n_wait;
            r_seg      <= n_seg;
            r_exp      <= n_exp;
            r_cnt      <= n_cnt;
            r_miss     <= n_miss;
            r_link     <= n_link;
            r_q        <= n_q;
            r_r        <= n_r;
            r_ucur     <= n_ucur;
            r_dcnt     <= n_dcnt;
            r_dq       <= n_dq;
            r_rem      <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_in <= i_in_data;
        end
    end

    assign o_busy = r_in_valid;
    assign o_hold = (u_eff != r_ucur) || (r_dcnt != 5'd0);

`ifndef SYNTHESIS
    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_res.capture_done) |=> (r_phase == PH_IDLE))
        else $error("capture did not return to idle after its last beat");
    a_units_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_res.pulse_valid) |-> (o_res.pulse_units != 16'd0))
        else $error("finished segment reported with zero units");
    a_idle_needs_arm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_phase == PH_IDLE) && !(r_in_valid && r_in.arm)) |=> (r_phase == PH_IDLE))
        else $error("capture left idle without an arm strobe");
    a_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dcnt != 5'd0) |-> !r_in_valid)
        else $error("sample processed while the quotient was being rebuilt");
`endif

endmodule

// ===== hdl/pwc_out_buf.sv =====
// Result register with a skid stage for the output channel.
// Lets the core keep accepting samples while a result beat waits; uses pwc_pkg.
module pwc_out_buf import pwc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out      i_data,
    input  logic      i_stall,
    output logic      o_valid,
    output t_out      o_data,
    output t_buf_stat o_stat
);

    logic r_hv, r_sv;
    t_out r_head, r_skid;
    logic pop;

    assign pop = r_hv && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
            r_sv <= 1'b0;
        end else if (pop) begin
            if (r_sv) begin
                r_hv <= 1'b1;
                r_sv <= i_push;
            end else begin
                r_hv <= i_push;
            end
        end else if (!r_hv) begin
            r_hv <= i_push;
        end else if (i_push) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_sv) begin
                r_head <= r_skid;
                if (i_push) begin
                    r_skid <= i_data;
                end
            end else if (i_push) begin
                r_head <= i_data;
            end
        end else if (!r_hv) begin
            if (i_push) begin
                r_head <= i_data;
            end
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

    assign o_valid = r_hv;
    assign o_data  = r_head;
    assign o_stat  = '{head_valid: r_hv, skid_valid: r_sv, pop: pop};

`ifndef SYNTHESIS
    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_hv)
        else $error("skid stage holds a beat while the head is empty");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && r_hv && r_sv) |-> pop)
        else $error("result beat pushed into a full buffer");
    a_skid_refills_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && r_sv) |=> r_hv)
        else $error("skid beat lost when the head was taken");
`endif

endmodule

// ===== dv/pwc_pulse_check.sv =====
// Prediction and checking for the pulse width capture block.
// Watches the sample, result and register write ports and compares results in order.
// Depends on pwc_pkg for the beat structs, register indexes and end codes.
module pwc_pulse_check import pwc_pkg::*; #(
    parameter int MAX_PULSES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in                   i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out                  i_out_data,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_reports_due,
    output int                    o_reports_seen,
    output int                    o_captures_closed,
    output int                    o_in_stall_cycles
);

    t_cfg        cfg;
    t_phase      phase;
    logic [23:0] wait_ticks;
    logic [19:0] seg_ticks;
    logic        seg_level;
    logic [8:0]  seg_count;
    logic [3:0]  misses;
    logic        link;

    t_out reports_due[$];
    int   fails;
    int   seen;
    int   closed;
    int   held;

    function automatic logic [15:0] to_units(input logic [19:0] ticks);
        int unsigned u;
        int unsigned q;
        u = (cfg.unit_ticks == 0) ? 1 : cfg.unit_ticks;
        q = (ticks + u / 2) / u;
        if (q < 1) q = 1;
        if (q > UNITS_SAT) q = UNITS_SAT;
        return q[15:0];
    endfunction

    function automatic int unsigned pulse_cap();
        int unsigned m;
        m = cfg.max_pulses;
        if (m < 1) m = 1;
        if (m > MAX_PULSES) m = MAX_PULSES;
        return m;
    endfunction

    function automatic void close_capture();
        if (seg_count > 0) begin
            misses = '0;
            link   = 1'b1;
        end else begin
            if (misses < MISS_SAT) misses++;
            if (misses >= cfg.miss_limit) link = 1'b0;
        end
        phase = PH_IDLE;
    endfunction

    function automatic logic predict_tick(input t_in beat, output t_out rep);
        int unsigned nxt;
        logic        emit;
        emit = 1'b0;
        rep  = '0;
        if (beat.arm) begin
            phase      = PH_WAIT;
            wait_ticks = '0;
            seg_ticks  = '0;
            seg_level  = 1'b0;
            seg_count  = '0;
        end
        case (phase)
            PH_WAIT: begin
                if (!beat.line_level) begin
                    phase     = PH_MEAS;
                    seg_level = 1'b0;
                    seg_ticks = 20'd1;
                end else begin
                    nxt = wait_ticks + 1;
                    if (nxt > cfg.start_timeout_ticks) begin
                        emit             = 1'b1;
                        rep.capture_done = 1'b1;
                        rep.end_reason   = END_NOSTART;
                        close_capture();
                    end else begin
                        wait_ticks = nxt[23:0];
                    end
                end
            end
            PH_MEAS: begin
                if (beat.line_level == seg_level) begin
                    nxt = seg_ticks + 1;
                    if (nxt > cfg.idle_limit_ticks) begin
                        emit             = 1'b1;
                        rep.capture_done = 1'b1;
                        rep.end_reason   = END_IDLE;
                        close_capture();
                    end else begin
                        seg_ticks = nxt[19:0];
                    end
                end else begin
                    emit            = 1'b1;
                    rep.pulse_valid = 1'b1;
                    rep.pulse_level = seg_level;
                    rep.pulse_units = to_units(seg_ticks);
                    rep.pulse_index = seg_count[7:0];
                    seg_count++;
                    seg_level = ~seg_level;
                    seg_ticks = 20'd1;
                    if (seg_count >= pulse_cap()) begin
                        rep.capture_done = 1'b1;
                        rep.end_reason   = END_FULL;
                        close_capture();
                    end
                end
            end
            default: ;
        endcase
        rep.pulse_count = seg_count;
        rep.link_up     = link;
        return emit;
    endfunction

    function automatic string show(input t_out r);
        return $sformatf("valid=%0d level=%0d units=%0d index=%0d done=%0d end=%0d count=%0d link=%0d",
                         r.pulse_valid, r.pulse_level, r.pulse_units, r.pulse_index,
                         r.capture_done, r.end_reason, r.pulse_count, r.link_up);
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        t_out got;
        t_out rep;
        logic bad;
        if (!i_rst_n) begin
            cfg        = '{UNIT_RST, IDLE_LIMIT_RST, START_TIMEOUT_RST, MAX_PULSES_RST,
                           MISS_LIMIT_RST};
            phase      = PH_IDLE;
            wait_ticks = '0;
            seg_ticks  = '0;
            seg_level  = 1'b0;
            seg_count  = '0;
            misses     = '0;
            link       = 1'b0;
            reports_due.delete();
            fails      = 0;
            seen       = 0;
            closed     = 0;
            held       = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_UNIT:          cfg.unit_ticks          = i_cfg_data[15:0];
                    CFG_IDLE_LIMIT:    cfg.idle_limit_ticks    = i_cfg_data[19:0];
                    CFG_START_TIMEOUT: cfg.start_timeout_ticks = i_cfg_data[23:0];
                    CFG_MAX_PULSES:    cfg.max_pulses          = i_cfg_data[8:0];
                    CFG_MISS_LIMIT:    cfg.miss_limit          = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                seen++;
                if (reports_due.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("[%0t] result beat with nothing pending: %s", $realtime, show(got));
                end else begin
                    want = reports_due.pop_front();
                    if (want.capture_done) closed++;
                    bad = (got.pulse_valid  !== want.pulse_valid)
                       || (got.pulse_level  !== want.pulse_level)
                       || (got.pulse_units  !== want.pulse_units)
                       || (got.pulse_index  !== want.pulse_index)
                       || (got.capture_done !== want.capture_done)
                       || (got.end_reason   !== want.end_reason)
                       || (got.pulse_count  !== want.pulse_count)
                       || (got.link_up      !== want.link_up);
                    if (bad) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("[%0t] result beat %0d mismatch", $realtime, seen);
                            $display("    expected %s", show(want));
                            $display("    actual   %s", show(got));
                        end
                    end
                end
            end
            if (i_in_valid && i_in_stall) held++;
            if (i_in_valid && !i_in_stall) begin
                if (predict_tick(i_in_data, rep)) reports_due.push_back(rep);
            end
        end
        o_fail_count      <= fails;
        o_reports_due     <= reports_due.size();
        o_reports_seen    <= seen;
        o_captures_closed <= closed;
        o_in_stall_cycles <= held;
    end

endmodule

// ===== dv/tb_pulse_width_capture.sv =====
// Top of the pulse width capture testbench: clock, reset, sample stimulus and verdict.
// Drives directed and random captures through pulse_width_capture and checks them
// with pwc_pulse_check; depends on pwc_pkg.
module tb_pulse_width_capture;
    import pwc_pkg::*;

    localparam int MAX_PULSES  = 256;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 8;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    t_in                   in_data   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out                  out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_UNIT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int fail_count;
    int reports_due;
    int reports_seen;
    int captures_closed;
    int in_stall_cycles;

    int          cycles     = 0;
    int          send_pct   = 0;
    int          recv_pct   = 0;
    logic        hold_on    = 1'b0;
    int          samples    = 0;
    int unsigned sh_idle    = IDLE_LIMIT_RST;
    int unsigned sh_timeout = START_TIMEOUT_RST;
    int unsigned sh_maxp    = MAX_PULSES_RST;

    pulse_width_capture #(.MAX_PULSES(MAX_PULSES)) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    pwc_pulse_check #(.MAX_PULSES(MAX_PULSES)) pulse_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_in_data         (in_data),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_out_data        (out_data),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .o_fail_count      (fail_count),
        .o_reports_due     (reports_due),
        .o_reports_seen    (reports_seen),
        .o_captures_closed (captures_closed),
        .o_in_stall_cycles (in_stall_cycles)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results pending.", cycles, reports_due);
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk) begin
        out_stall <= hold_on || ($urandom_range(99) < recv_pct);
    end

    task automatic set_idling(input int sender, input int receiver);
        send_pct = sender;
        recv_pct <= receiver;
    endtask

    task automatic offer(input logic arm, input logic line);
        while (send_pct != 0 && $urandom_range(99) < send_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t_in'{arm: arm, line_level: line};
        do @(posedge clk); while (in_stall);
    endtask

    task automatic tick(input logic arm, input logic line);
        offer(arm, line);
        samples++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (reports_due != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic set_regs(input int unsigned unit, input int unsigned idle,
                            input int unsigned timeout, input int unsigned maxp,
                            input int unsigned miss);
        drain();
        write_reg(CFG_UNIT, CFG_DATA_W'(unit));
        write_reg(CFG_IDLE_LIMIT, CFG_DATA_W'(idle));
        write_reg(CFG_START_TIMEOUT, CFG_DATA_W'(timeout));
        write_reg(CFG_MAX_PULSES, CFG_DATA_W'(maxp));
        write_reg(CFG_MISS_LIMIT, CFG_DATA_W'(miss));
        cfg_we     <= 1'b0;
        sh_idle    = idle;
        sh_timeout = timeout;
        sh_maxp    = maxp;
    endtask

    task automatic random_regs();
        int unsigned unit;
        int unsigned idle;
        int unsigned timeout;
        int unsigned maxp;
        case ($urandom_range(9))
            0:       unit = 0;
            1:       unit = 65535;
            default: unit = $urandom_range(1, 6);
        endcase
        case ($urandom_range(9))
            0:       idle = 1;
            1:       idle = 1048575;
            default: idle = $urandom_range(2, 25);
        endcase
        case ($urandom_range(9))
            0:       timeout = 0;
            1:       timeout = 16777215;
            default: timeout = $urandom_range(1, 15);
        endcase
        case ($urandom_range(9))
            0:       maxp = 0;
            1:       maxp = 511;
            2:       maxp = 256;
            default: maxp = $urandom_range(1, 24);
        endcase
        set_regs(unit, idle, timeout, maxp, $urandom_range(15));
    endtask

    // One capture: a wait stretch, then alternating segments. Some captures time out,
    // some end on an idle gap, and some are cut short so that the next arm abandons them.
    task automatic gen_capture();
        int   n_high;
        int   n_seg;
        int   seg_len;
        int   len_cap;
        int   pmax;
        logic lvl;
        len_cap = (sh_idle < 40) ? sh_idle : 40;
        pmax    = (sh_maxp < 1) ? 1 : ((sh_maxp > MAX_PULSES) ? MAX_PULSES : sh_maxp);
        if (sh_timeout <= 30 && $urandom_range(99) < 20)
            n_high = sh_timeout + 1;
        else
            n_high = $urandom_range(0, (sh_timeout < 6) ? sh_timeout : 6);
        if (n_high == 0) begin
            tick(1'b1, 1'b0);
        end else begin
            tick(1'b1, 1'b1);
            repeat (n_high - 1) tick(1'b0, 1'b1);
            if (n_high > sh_timeout) return;
            tick(1'b0, 1'b0);
        end
        n_seg = $urandom_range(1, (pmax < 24) ? pmax + 1 : 24);
        lvl   = 1'b0;
        for (int s = 0; s < n_seg; s++) begin
            if (sh_idle <= 40 && $urandom_range(99) < 8) begin
                repeat (sh_idle) tick(1'b0, lvl);
                return;
            end
            seg_len = $urandom_range(1, len_cap);
            repeat (seg_len - 1) tick(1'b0, lvl);
            if ($urandom_range(99) < 4) return;
            lvl = ~lvl;
            tick(1'b0, lvl);
        end
    endtask

    initial begin
        int target;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a short low segment rounds up to one unit.
        tick(1'b1, 1'b0);
        tick(1'b0, 1'b0);
        tick(1'b0, 1'b0);
        tick(1'b0, 1'b1);

        // A zero unit acts as one; miss limit zero drops the link on any miss.
        set_regs(0, 3, 2, 2, 0);
        tick(1'b1, 1'b1);
        tick(1'b0, 1'b1);
        tick(1'b0, 1'b1);
        offer(1'b0, 1'b0);
        tick(1'b1, 1'b0);
        tick(1'b0, 1'b0);
        tick(1'b0, 1'b1);
        tick(1'b0, 1'b1);
        tick(1'b0, 1'b1);
        tick(1'b0, 1'b0);
        tick(1'b1, 1'b0);
        repeat (3) tick(1'b0, 1'b0);

        // Largest unit, max pulses of zero clamped to one, idle and start limits of one.
        set_regs(65535, 1, 1, 0, 15);
        tick(1'b1, 1'b0);
        tick(1'b0, 1'b1);
        tick(1'b1, 1'b1);
        tick(1'b0, 1'b1);
        tick(1'b1, 1'b0);
        tick(1'b0, 1'b0);

        // Back to back empty captures push the miss count into saturation.
        set_idling(9, 9);
        set_regs(1, 1048575, 0, 511, 15);
        repeat (17) tick(1'b1, 1'b1);

        // Long receiver hold-off while one-tick segments fill a 256 pulse capture.
        set_idling(0, 0);
        set_regs(1, 40, 5, 511, 3);
        fork
            begin
                hold_on <= 1'b1;
                repeat (200) @(posedge clk);
                hold_on <= 1'b0;
            end
        join_none
        tick(1'b1, 1'b0);
        for (int i = 1; i < 300; i++) tick(1'b0, i[0]);

        for (int p = 0; p < 12; p++) begin
            case (p % 4)
                0:       set_idling(0, 0);
                1:       set_idling(88, 0);
                2:       set_idling(0, 88);
                default: set_idling(9, 9);
            endcase
            random_regs();
            target = samples + 75;
            while (samples < target) begin
                if ($urandom_range(99) < 15)
                    repeat ($urandom_range(1, 4)) offer(1'b0, $urandom_range(1));
                gen_capture();
            end
        end

        drain();
        $display("Covered %0d sample beats and %0d result beats, %0d captures closed.",
                 samples, reports_seen, captures_closed);
        $display("Sample input held off for %0d cycles; %0d mismatches.",
                 in_stall_cycles, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
